// ===== rtl/core/dpjs_pkg.sv =====
// Shared types, codes and rank functions for the dedup priority job scheduler.
// No dependencies; used by every module of the block.

package dpjs_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int KEY_BITS_DEF    = 64;
   localparam int SEQ_BITS_DEF    = 32;

   localparam int OP_BITS     = 2;
   localparam int KIND_BITS   = 3;
   localparam int PERIOD_BITS = 3;
   localparam int PRANK_BITS  = 3;
   localparam int STATUS_BITS = 4;
   localparam int DROP_BITS   = 5;

   typedef enum logic [OP_BITS-1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_COMPLETE = 2'd2,
      OP_FLUSH    = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ACCEPTED        = 4'd0,
      ST_DUPLICATE       = 4'd1,
      ST_FULL            = 4'd2,
      ST_DISPATCHED      = 4'd3,
      ST_EMPTY           = 4'd4,
      ST_BUSY            = 4'd5,
      ST_COMPLETED       = 4'd6,
      ST_FLUSHED         = 4'd7,
      ST_NOTHING_RUNNING = 4'd8
   } status_type;

   localparam logic [KIND_BITS-1:0] KIND_SUMMARY = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_DAILY   = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_WEEKLY  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_POWER   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_INSIGHT = 3'd4;

   localparam logic [PERIOD_BITS-1:0] PERIOD_1YR   = 3'd4;
   localparam logic [PRANK_BITS-1:0]  PRANK_OTHER  = 3'd5;
   localparam logic [PRANK_BITS-1:0]  PRANK_UNKNOWN = 3'd7;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_last;
   } ctl_sts_type;

   function automatic logic [PRANK_BITS-1:0] period_rank(
      input logic [KIND_BITS-1:0]   kind,
      input logic [PERIOD_BITS-1:0] period
   );
      logic [PRANK_BITS-1:0] rank;
      case (kind)
         KIND_SUMMARY: rank = 3'd0;
         KIND_DAILY:   rank = 3'd1;
         KIND_WEEKLY:  rank = 3'd2;
         KIND_POWER:   rank = (period <= PERIOD_1YR) ? PRANK_BITS'(period) : PRANK_OTHER;
         KIND_INSIGHT: rank = 3'd1;
         default:      rank = PRANK_UNKNOWN;
      endcase
      return rank;
   endfunction

   function automatic logic domain_rank(
      input logic [KIND_BITS-1:0] kind,
      input logic                 sleep_surface
   );
      logic rank;
      if (kind inside {KIND_SUMMARY, KIND_DAILY, KIND_WEEKLY}) begin
         rank = 1'b0;
      end else if (kind == KIND_INSIGHT) begin
         rank = ~sleep_surface;
      end else begin
         rank = 1'b1;
      end
      return rank;
   endfunction

endpackage

// ===== rtl/core/dpjs_ctrl.sv =====
// Sequencer for the job scheduler: load, table scan, drain and finish steps.
// Depends on dpjs_pkg for the command and status structs.

module dpjs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  dpjs_pkg::ctl_sts_type sts,
   output dpjs_pkg::ctl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_comb begin
      cmd.load   = (state_ff == S_IDLE) && start;
      cmd.step   = (state_ff == S_SCAN);
      cmd.finish = (state_ff == S_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  busy_ff  <= 1'b1;
                  state_ff <= sts.need_scan ? S_SCAN : S_FINISH;
               end
            end
            S_SCAN: begin
               if (sts.scan_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               busy_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: begin
               busy_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/core/dpjs_datapath.sv =====
// Job table memory, running job, sequence counter, scan accumulators and result registers.
// Depends on dpjs_pkg for codes, rank functions and the command and status structs.

module dpjs_datapath #(
   parameter int TABLE_DEPTH = dpjs_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = dpjs_pkg::KEY_BITS_DEF,
   parameter int SEQ_BITS    = dpjs_pkg::SEQ_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dpjs_pkg::ctl_cmd_type                 cmd,
   output dpjs_pkg::ctl_sts_type                 sts,
   input  logic [dpjs_pkg::OP_BITS-1:0]          req_opcode,
   input  logic [KEY_BITS-1:0]                   req_job_key,
   input  logic [dpjs_pkg::KIND_BITS-1:0]        req_job_kind,
   input  logic [dpjs_pkg::PERIOD_BITS-1:0]      req_period_code,
   input  logic                                  req_sleep_surface,
   input  logic                                  req_job_ok,
   output logic                                  rsp_valid,
   output logic [dpjs_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [KEY_BITS-1:0]                   rsp_out_key,
   output logic [dpjs_pkg::KIND_BITS-1:0]        rsp_out_kind,
   output logic [SEQ_BITS-1:0]                   rsp_out_seq,
   output logic                                  rsp_done_ok,
   output logic [dpjs_pkg::DROP_BITS-1:0]        rsp_dropped_count
);

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_DEPTH - 1);

   logic [KEY_BITS-1:0]             key_mem   [TABLE_DEPTH];
   logic [dpjs_pkg::KIND_BITS-1:0]  kind_mem  [TABLE_DEPTH];
   logic [dpjs_pkg::PRANK_BITS-1:0] prank_mem [TABLE_DEPTH];
   logic                            drank_mem [TABLE_DEPTH];
   logic [SEQ_BITS-1:0]             seq_mem   [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic                   running_valid_ff;
   logic [KEY_BITS-1:0]    running_key_ff;
   logic [SEQ_BITS-1:0]    next_seq_ff;

   dpjs_pkg::op_type                op_ff;
   logic [KEY_BITS-1:0]             key_ff;
   logic [dpjs_pkg::KIND_BITS-1:0]  kind_ff;
   logic [dpjs_pkg::PRANK_BITS-1:0] prank_ff;
   logic                            drank_ff;
   logic                            ok_ff;

   logic [IDX_BITS-1:0]             rd_idx_ff;
   logic                            cmp_en_ff;
   logic [IDX_BITS-1:0]             cmp_idx_ff;
   logic                            rd_valid_ff;
   logic [KEY_BITS-1:0]             rd_key_ff;
   logic [dpjs_pkg::KIND_BITS-1:0]  rd_kind_ff;
   logic [dpjs_pkg::PRANK_BITS-1:0] rd_prank_ff;
   logic                            rd_drank_ff;
   logic [SEQ_BITS-1:0]             rd_seq_ff;

   logic                            dup_ff;
   logic                            slot_found_ff;
   logic [IDX_BITS-1:0]             slot_ff;
   logic                            best_found_ff;
   logic [IDX_BITS-1:0]             best_idx_ff;
   logic [KEY_BITS-1:0]             best_key_ff;
   logic [dpjs_pkg::KIND_BITS-1:0]  best_kind_ff;
   logic [dpjs_pkg::PRANK_BITS-1:0] best_prank_ff;
   logic                            best_drank_ff;
   logic [SEQ_BITS-1:0]             best_seq_ff;
   logic [CNT_BITS-1:0]             count_ff;

   logic                            rsp_valid_ff;
   dpjs_pkg::status_type            status_ff;
   logic [KEY_BITS-1:0]             out_key_ff;
   logic [dpjs_pkg::KIND_BITS-1:0]  out_kind_ff;
   logic [SEQ_BITS-1:0]             out_seq_ff;
   logic                            done_ok_ff;
   logic [dpjs_pkg::DROP_BITS-1:0]  dropped_ff;

   logic                            better;
   logic                            do_write;
   logic                            do_dispatch;
   dpjs_pkg::status_type            status_in;
   logic [KEY_BITS-1:0]             out_key_in;
   logic [dpjs_pkg::KIND_BITS-1:0]  out_kind_in;
   logic [SEQ_BITS-1:0]             out_seq_in;
   logic                            done_ok_in;
   logic [dpjs_pkg::DROP_BITS-1:0]  dropped_in;

   always_comb begin
      sts.need_scan = (dpjs_pkg::op_type'(req_opcode) != dpjs_pkg::OP_COMPLETE)
                      && !((dpjs_pkg::op_type'(req_opcode) == dpjs_pkg::OP_DISPATCH)
                           && running_valid_ff);
      sts.scan_last = (rd_idx_ff == LAST_IDX);
   end

   always_comb begin
      better = !best_found_ff
               || (rd_prank_ff < best_prank_ff)
               || ((rd_prank_ff == best_prank_ff) && (rd_drank_ff < best_drank_ff))
               || ((rd_prank_ff == best_prank_ff) && (rd_drank_ff == best_drank_ff)
                   && (rd_seq_ff < best_seq_ff));
   end

   always_comb begin
      do_write    = 1'b0;
      do_dispatch = 1'b0;
      status_in   = dpjs_pkg::ST_FLUSHED;
      out_key_in  = '0;
      out_kind_in = '0;
      out_seq_in  = '0;
      done_ok_in  = 1'b0;
      dropped_in  = '0;
      case (op_ff)
         dpjs_pkg::OP_ENQUEUE: begin
            if (dup_ff) begin
               status_in = dpjs_pkg::ST_DUPLICATE;
            end else if (!slot_found_ff) begin
               status_in = dpjs_pkg::ST_FULL;
            end else begin
               do_write   = 1'b1;
               status_in  = dpjs_pkg::ST_ACCEPTED;
               out_seq_in = next_seq_ff;
            end
         end
         dpjs_pkg::OP_DISPATCH: begin
            if (running_valid_ff) begin
               status_in = dpjs_pkg::ST_BUSY;
            end else if (!best_found_ff) begin
               status_in = dpjs_pkg::ST_EMPTY;
            end else begin
               do_dispatch = 1'b1;
               status_in   = dpjs_pkg::ST_DISPATCHED;
               out_key_in  = best_key_ff;
               out_kind_in = best_kind_ff;
               out_seq_in  = best_seq_ff;
            end
         end
         dpjs_pkg::OP_COMPLETE: begin
            if (running_valid_ff) begin
               status_in  = dpjs_pkg::ST_COMPLETED;
               out_key_in = running_key_ff;
               done_ok_in = ok_ff;
            end else begin
               status_in = dpjs_pkg::ST_NOTHING_RUNNING;
            end
         end
         default: begin
            status_in  = dpjs_pkg::ST_FLUSHED;
            dropped_in = dpjs_pkg::DROP_BITS'(count_ff);
         end
      endcase
   end

   // latch the item (scan state is cleared on the same load in the block below)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= dpjs_pkg::op_type'(req_opcode);
         key_ff   <= req_job_key;
         kind_ff  <= req_job_kind;
         prank_ff <= dpjs_pkg::period_rank(req_job_kind, req_period_code);
         drank_ff <= dpjs_pkg::domain_rank(req_job_kind, req_sleep_surface);
         ok_ff    <= req_job_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rd_key_ff   <= key_mem[rd_idx_ff];
         rd_kind_ff  <= kind_mem[rd_idx_ff];
         rd_prank_ff <= prank_mem[rd_idx_ff];
         rd_drank_ff <= drank_mem[rd_idx_ff];
         rd_seq_ff   <= seq_mem[rd_idx_ff];
         rd_valid_ff <= valid_ff[rd_idx_ff];
         cmp_idx_ff  <= rd_idx_ff;
      end
      if (cmd.finish && do_write) begin
         key_mem[slot_ff]   <= key_ff;
         kind_mem[slot_ff]  <= kind_ff;
         prank_mem[slot_ff] <= prank_ff;
         drank_mem[slot_ff] <= drank_ff;
         seq_mem[slot_ff]   <= next_seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_idx_ff     <= '0;
         dup_ff        <= running_valid_ff && (running_key_ff == req_job_key);
         slot_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (cmd.step) begin
            rd_idx_ff <= rd_idx_ff + IDX_BITS'(1);
         end
         if (cmp_en_ff) begin
            if (rd_valid_ff) begin
               count_ff <= count_ff + CNT_BITS'(1);
               if (rd_key_ff == key_ff) begin
                  dup_ff <= 1'b1;
               end
               if (better) begin
                  best_found_ff <= 1'b1;
                  best_idx_ff   <= cmp_idx_ff;
                  best_key_ff   <= rd_key_ff;
                  best_kind_ff  <= rd_kind_ff;
                  best_prank_ff <= rd_prank_ff;
                  best_drank_ff <= rd_drank_ff;
                  best_seq_ff   <= rd_seq_ff;
               end
            end else if (!slot_found_ff) begin
               slot_found_ff <= 1'b1;
               slot_ff       <= cmp_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff         <= '0;
         running_valid_ff <= 1'b0;
         running_key_ff   <= '0;
         next_seq_ff      <= '0;
         cmp_en_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cmp_en_ff    <= cmd.step;
         rsp_valid_ff <= cmd.finish;
         if (cmd.finish) begin
            case (op_ff)
               dpjs_pkg::OP_ENQUEUE: begin
                  next_seq_ff <= next_seq_ff + SEQ_BITS'(1);
                  if (do_write) begin
                     valid_ff[slot_ff] <= 1'b1;
                  end
               end
               dpjs_pkg::OP_DISPATCH: begin
                  if (do_dispatch) begin
                     valid_ff[best_idx_ff] <= 1'b0;
                     running_valid_ff      <= 1'b1;
                     running_key_ff        <= best_key_ff;
                  end
               end
               dpjs_pkg::OP_COMPLETE: begin
                  running_valid_ff <= 1'b0;
                  running_key_ff   <= '0;
               end
               default: begin
                  valid_ff         <= '0;
                  running_valid_ff <= 1'b0;
                  running_key_ff   <= '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff   <= status_in;
         out_key_ff  <= out_key_in;
         out_kind_ff <= out_kind_in;
         out_seq_ff  <= out_seq_in;
         done_ok_ff  <= done_ok_in;
         dropped_ff  <= dropped_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_key       = out_key_ff;
   assign rsp_out_kind      = out_kind_ff;
   assign rsp_out_seq       = out_seq_ff;
   assign rsp_done_ok       = done_ok_ff;
   assign rsp_dropped_count = dropped_ff;

endmodule

// ===== rtl/core/dedup_priority_job_scheduler.sv =====
// Enqueue, flush and idle dispatch scan the whole table, one entry per cycle, then pass
// through the drain and finish steps before the rsp_valid strobe is raised; complete and
// dispatch while a job runs skip the scan and go straight to the finish step.
// Flow: one item at a time; busy is high from accept until the result cycle and the
// next item is taken at the edge that ends it; results never stall.
// Reset (synchronous, active high) empties the table, clears the running job and sequence.

module dedup_priority_job_scheduler #(
   parameter int TABLE_DEPTH = dpjs_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = dpjs_pkg::KEY_BITS_DEF,
   parameter int SEQ_BITS    = dpjs_pkg::SEQ_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dpjs_pkg::OP_BITS-1:0]     req_opcode,
   input  logic [KEY_BITS-1:0]              req_job_key,
   input  logic [dpjs_pkg::KIND_BITS-1:0]   req_job_kind,
   input  logic [dpjs_pkg::PERIOD_BITS-1:0] req_period_code,
   input  logic                             req_sleep_surface,
   input  logic                             req_job_ok,
   output logic                             rsp_valid,
   output logic [dpjs_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [KEY_BITS-1:0]              rsp_out_key,
   output logic [dpjs_pkg::KIND_BITS-1:0]   rsp_out_kind,
   output logic [SEQ_BITS-1:0]              rsp_out_seq,
   output logic                             rsp_done_ok,
   output logic [dpjs_pkg::DROP_BITS-1:0]   rsp_dropped_count
);

   dpjs_pkg::ctl_cmd_type cmd;
   dpjs_pkg::ctl_sts_type sts;

   dpjs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   dpjs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .SEQ_BITS    (SEQ_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_job_key       (req_job_key),
      .req_job_kind      (req_job_kind),
      .req_period_code   (req_period_code),
      .req_sleep_surface (req_sleep_surface),
      .req_job_ok        (req_job_ok),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_seq       (rsp_out_seq),
      .rsp_done_ok       (rsp_done_ok),
      .rsp_dropped_count (rsp_dropped_count)
   );

endmodule

// ===== rtl/core/dpjs_checker.sv =====
// Port-level checks for the job scheduler, attached to the top level by bind.
// Depends on dpjs_pkg for status codes.

module dpjs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [dpjs_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [dpjs_pkg::DROP_BITS-1:0]   rsp_dropped_count,
   input logic                             rsp_done_ok
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_busy_fall_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("item finished without a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == dpjs_pkg::ST_ACCEPTED))
         |-> (rsp_dropped_count == '0) && !rsp_done_ok)
      else $error("accepted result carries flush or complete fields");

endmodule

bind dedup_priority_job_scheduler dpjs_checker u_dpjs_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_dropped_count (rsp_dropped_count),
   .rsp_done_ok       (rsp_done_ok)
);
